// File: hw/rtl/bsu_pkg.sv
`default_nettype none

package bsu_pkg;

  localparam int unsigned PosW      = 26;
  localparam int unsigned WordW     = 32;
  localparam int unsigned LimitW    = 7;
  localparam int unsigned OpW       = 6;
  localparam int unsigned MaskW     = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned ResCntW   = 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // reset value of the opcode limit register
  localparam logic [LimitW-1:0] LimitReset = 7'd64;

  // argument tags in the low two bits of an opcode byte
  localparam logic [1:0] TagByte = 2'd2;
  localparam logic [1:0] TagWord = 2'd3;

  // last byte of a four byte argument
  localparam logic [1:0] ArgLastByte = 2'd3;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_END    = 2'd1,
    OP_START  = 2'd2,
    OP_IGNORE = 2'd3
  } oper_e;

  typedef enum logic [2:0] {
    ST_WORD     = 3'd0,
    ST_TERM     = 3'd1,
    ST_BAD_OP   = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_MISMATCH = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_ARG1   = 2'd1,
    PH_ARG4   = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CODE_LEN  = 2'd0,
    REG_OP_LIMIT  = 2'd1,
    REG_LONG_MASK = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [WordW-1:0] code_word;
    logic [PosW-1:0]  word_index;
    status_e          status;
    logic             last;
  } result_t;

  // outcome of closing a word at a given index
  typedef struct packed {
    logic            emit;
    logic            stop;
    result_t         res;
    logic [PosW-1:0] next_pos;
  } fin_t;

  function automatic result_t make_res(input logic [WordW-1:0] word,
                                       input logic [PosW-1:0] idx,
                                       input status_e st);
    result_t r;
    r.code_word  = word;
    r.word_index = idx;
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

  // word written at idx: check for overshoot or a regular end of section
  function automatic fin_t finish_word(input logic [PosW-1:0] idx,
                                       input logic [PosW-1:0] code_len,
                                       input logic [LimitW-1:0] limit);
    fin_t f;
    logic [PosW:0] nxt;
    nxt        = {1'b0, idx} + (PosW+1)'(1);
    f          = '0;
    f.next_pos = nxt[PosW-1:0];
    if (idx >= code_len) begin
      f.emit = 1'b1;
      f.stop = 1'b1;
      f.res  = make_res('0, nxt[PosW-1:0], ST_MISMATCH);
    end else if (nxt == {1'b0, code_len}) begin
      f.emit = 1'b1;
      f.stop = 1'b1;
      f.res  = make_res(WordW'(limit), nxt[PosW-1:0], ST_TERM);
    end
    return f;
  endfunction

  // position at or past the end while waiting for an opcode
  function automatic result_t end_reached(input logic [PosW-1:0] pos,
                                          input logic [PosW-1:0] code_len,
                                          input logic [LimitW-1:0] limit);
    if (pos == code_len) begin
      return make_res(WordW'(limit), pos, ST_TERM);
    end
    return make_res('0, pos, ST_MISMATCH);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bytecode_stream_unpacker_core.sv
// Bytecode stream unpacker.
// Input stream: one beat per raw byte. s_axis_tuser carries the operation
// (data byte, input ended, start new section, ignore), s_axis_tdata the byte.
// Output stream: one beat per code word or status: tdata holds the code word
// and its index, tuser the status, tlast marks the final beat caused by one
// input beat. Errors and the terminator always carry tlast.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 code length, 1 opcode limit, 2 long mask); write only while idle.
// The results of an accepted input beat are registered in the result queue;
// with the queue empty, the first is shown in the cycle after that beat.
// Throughput: one input beat per cycle while each byte yields at most one
// result and the output is not stalled. A byte yielding two or three results
// takes one output beat per result; the input is held off by a four entry
// result queue, which takes a new beat whenever at most one result waits.
// Reset: the section state is cleared, code length 0, opcode limit 64,
// long mask 0, the result queue is emptied.
// A stalled receiver fills the queue; the input then stalls with no loss.
`default_nettype none

module bytecode_stream_unpacker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input beats
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result beats
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [63:0] m_axis_tdata,   // [31:0] code_word, [57:32] word_index
  output      logic [2:0]  m_axis_tuser,   // [2:0] status
  output      logic        m_axis_tlast,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);

  // configuration registers
  logic [bsu_pkg::PosW-1:0]   code_len_q;
  logic [bsu_pkg::LimitW-1:0] op_limit_q;
  logic [bsu_pkg::MaskW-1:0]  long_mask_q;

  // section state
  bsu_pkg::phase_e             phase_q, phase_d;
  logic [1:0]                  abs_q, abs_d;
  logic [bsu_pkg::WordW-1:0]   acc_q, acc_d;
  logic [bsu_pkg::PosW-1:0]    pos_q, pos_d;
  logic                        stopped_q, stopped_d;

  // decode results
  bsu_pkg::result_t            res_d [bsu_pkg::MaxRes];
  logic [bsu_pkg::ResCntW-1:0] n_res;
  bsu_pkg::fin_t               fin;
  logic [bsu_pkg::WordW-1:0]   acc_new;
  logic [bsu_pkg::PosW-1:0]    pos_inc;
  logic [bsu_pkg::OpW-1:0]     opc;
  logic [1:0]                  tag;
  logic                        has_arg;
  logic                        in_acc;

  // result queue
  bsu_pkg::result_t             fifo_q [bsu_pkg::FifoDepth];
  logic [bsu_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [bsu_pkg::FifoCntW-1:0] count_q;
  logic                         pop;
  bsu_pkg::result_t             head;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (count_q <= bsu_pkg::FifoCntW'(1));
  assign pop           = m_axis_tvalid && m_axis_tready;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_len_q  <= '0;
      op_limit_q  <= bsu_pkg::LimitReset;
      long_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bsu_pkg::cfg_reg_e'(cfg_idx_i))
        bsu_pkg::REG_CODE_LEN:  code_len_q  <= cfg_data_i[bsu_pkg::PosW-1:0];
        bsu_pkg::REG_OP_LIMIT:  op_limit_q  <= cfg_data_i[bsu_pkg::LimitW-1:0];
        bsu_pkg::REG_LONG_MASK: long_mask_q <= cfg_data_i[bsu_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  // per-beat decode: next section state and up to three results
  assign opc     = s_axis_tdata[7:2];
  assign tag     = s_axis_tdata[1:0];
  assign has_arg = (tag != bsu_pkg::TagWord) || long_mask_q[opc];
  assign pos_inc = pos_q + bsu_pkg::PosW'(1);
  assign acc_new = acc_q | (bsu_pkg::WordW'(s_axis_tdata) << {abs_q, 3'b000});

  always_comb begin
    phase_d   = phase_q;
    abs_d     = abs_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    stopped_d = stopped_q;
    n_res     = '0;
    fin       = '0;
    for (int k = 0; k < bsu_pkg::MaxRes; k++) begin
      res_d[k] = '0;
    end

    if (in_acc) begin
      case (s_axis_tuser)
        bsu_pkg::OP_START: begin
          phase_d   = bsu_pkg::PH_OPCODE;
          abs_d     = '0;
          acc_d     = '0;
          pos_d     = '0;
          stopped_d = 1'b0;
          if (code_len_q == '0) begin
            res_d[0]  = bsu_pkg::make_res(bsu_pkg::WordW'(op_limit_q), '0,
                                          bsu_pkg::ST_TERM);
            n_res     = 2'd1;
            stopped_d = 1'b1;
          end
        end
        bsu_pkg::OP_END: begin
          if (!stopped_q) begin
            stopped_d = 1'b1;
            n_res     = 2'd1;
            if (phase_q == bsu_pkg::PH_OPCODE && pos_q >= code_len_q) begin
              res_d[0] = bsu_pkg::end_reached(pos_q, code_len_q, op_limit_q);
            end else begin
              phase_d  = bsu_pkg::PH_OPCODE;
              res_d[0] = bsu_pkg::make_res('0, pos_q, bsu_pkg::ST_TRUNC);
            end
          end
        end
        bsu_pkg::OP_DATA: begin
          if (!stopped_q) begin
            case (phase_q)
              bsu_pkg::PH_OPCODE: begin
                if (pos_q >= code_len_q) begin
                  res_d[0]  = bsu_pkg::end_reached(pos_q, code_len_q, op_limit_q);
                  n_res     = 2'd1;
                  stopped_d = 1'b1;
                end else if ({1'b0, opc} >= op_limit_q) begin
                  res_d[0]  = bsu_pkg::make_res(bsu_pkg::WordW'(opc), pos_q,
                                                bsu_pkg::ST_BAD_OP);
                  n_res     = 2'd1;
                  stopped_d = 1'b1;
                end else begin
                  res_d[0] = bsu_pkg::make_res(bsu_pkg::WordW'(opc), pos_q,
                                               bsu_pkg::ST_WORD);
                  if (!has_arg) begin
                    // opcode word alone
                    fin       = bsu_pkg::finish_word(pos_q, code_len_q, op_limit_q);
                    res_d[1]  = fin.res;
                    n_res     = fin.emit ? 2'd2 : 2'd1;
                    pos_d     = fin.next_pos;
                    stopped_d = fin.stop;
                  end else if (tag < bsu_pkg::TagByte) begin
                    // tag is the argument itself
                    res_d[1]  = bsu_pkg::make_res(bsu_pkg::WordW'(tag), pos_inc,
                                                  bsu_pkg::ST_WORD);
                    fin       = bsu_pkg::finish_word(pos_inc, code_len_q, op_limit_q);
                    res_d[2]  = fin.res;
                    n_res     = fin.emit ? 2'd3 : 2'd2;
                    pos_d     = fin.next_pos;
                    stopped_d = fin.stop;
                  end else if (tag == bsu_pkg::TagByte) begin
                    n_res   = 2'd1;
                    pos_d   = pos_inc;
                    phase_d = bsu_pkg::PH_ARG1;
                  end else begin
                    n_res   = 2'd1;
                    pos_d   = pos_inc;
                    phase_d = bsu_pkg::PH_ARG4;
                    abs_d   = '0;
                    acc_d   = '0;
                  end
                end
              end
              bsu_pkg::PH_ARG1: begin
                phase_d   = bsu_pkg::PH_OPCODE;
                res_d[0]  = bsu_pkg::make_res(bsu_pkg::WordW'(s_axis_tdata), pos_q,
                                              bsu_pkg::ST_WORD);
                fin       = bsu_pkg::finish_word(pos_q, code_len_q, op_limit_q);
                res_d[1]  = fin.res;
                n_res     = fin.emit ? 2'd2 : 2'd1;
                pos_d     = fin.next_pos;
                stopped_d = fin.stop;
              end
              default: begin
                // four byte argument, least significant byte first
                if (abs_q == bsu_pkg::ArgLastByte) begin
                  phase_d   = bsu_pkg::PH_OPCODE;
                  abs_d     = '0;
                  acc_d     = '0;
                  res_d[0]  = bsu_pkg::make_res(acc_new, pos_q, bsu_pkg::ST_WORD);
                  fin       = bsu_pkg::finish_word(pos_q, code_len_q, op_limit_q);
                  res_d[1]  = fin.res;
                  n_res     = fin.emit ? 2'd2 : 2'd1;
                  pos_d     = fin.next_pos;
                  stopped_d = fin.stop;
                end else begin
                  acc_d = acc_new;
                  abs_d = abs_q + 2'd1;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    // mark the final result of this beat
    if (n_res != '0) begin
      res_d[n_res - 2'd1].last = 1'b1;
    end
  end

  // section state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bsu_pkg::PH_OPCODE;
      abs_q     <= '0;
      acc_q     <= '0;
      pos_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      abs_q     <= abs_d;
      acc_q     <= acc_d;
      pos_q     <= pos_d;
      stopped_q <= stopped_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < bsu_pkg::MaxRes; k++) begin
      if (bsu_pkg::ResCntW'(k) < n_res) begin
        fifo_q[wr_ptr_q + bsu_pkg::FifoPtrW'(k)] <= res_d[k];
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + bsu_pkg::FifoPtrW'(n_res);
      rd_ptr_q <= rd_ptr_q + bsu_pkg::FifoPtrW'(pop);
      count_q  <= count_q + bsu_pkg::FifoCntW'(n_res) - bsu_pkg::FifoCntW'(pop);
    end
  end

  // output beat
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {6'b0, head.word_index, head.code_word};
  assign m_axis_tuser  = head.status;
  assign m_axis_tlast  = head.last;

endmodule

`default_nettype wire

// File: hw/rtl/bsu_chk.sv
`default_nettype none

module bsu_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // terminator and errors end the results of their beat
  a_stop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != bsu_pkg::ST_WORD |-> m_axis_tlast)
    else $error("terminator or error without tlast");

  // terminator carries the opcode limit, a rejected opcode fits six bits; both words are checked to fit seven bits
  a_term_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == bsu_pkg::ST_TERM
      || m_axis_tuser == bsu_pkg::ST_BAD_OP) |-> m_axis_tdata[31:7] == '0)
    else $error("terminator or bad opcode word out of range");

  // truncation and mismatch report a zero word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == bsu_pkg::ST_TRUNC
      || m_axis_tuser == bsu_pkg::ST_MISMATCH) |-> m_axis_tdata[31:0] == '0)
    else $error("error beat with nonzero word");

  // no status code beyond length mismatch, and zero padding above the word index
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= bsu_pkg::ST_MISMATCH && m_axis_tdata[63:58] == '0)
    else $error("invalid status or padding on output");

endmodule

bind bytecode_stream_unpacker_core bsu_chk u_bsu_chk (.*);

`default_nettype wire
